// ----- rtl/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the periodic timer bank
// Request and result payloads, operation codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int unsigned TIMERS_DEF = 16;
  localparam int unsigned MAX_RES    = 16;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Remaining time is 34-bit signed, the update runs on 36 bits.
  localparam int unsigned REM_W  = 34;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned ELAP_W = 33;
  localparam logic signed [35:0] REM_MIN_36  = 36'shE_0000_0000;
  localparam logic [ELAP_W-1:0]  ELAPSED_MAX = 33'h1_0000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] period;
    logic [3:0]  timer_id;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_id;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_TICK_END
  } state_e;

  typedef struct packed {
    logic accept;
    logic add_step;
    logic tick_step;
    logic tick_end;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic slot_free;
  } sts_t;

endpackage

// ----- rtl/ptb_ram.sv -----
// ----------------------------------------------------------------------------
// ptb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptb_ctrl: controller of the periodic timer bank
// Sequences the slot walks for add and tick requests.
// ----------------------------------------------------------------------------
module ptb_ctrl
  import ptb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] mode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (mode_i == MODE_ADD) begin
            state_d = ST_ADD;
          end else if (mode_i == MODE_TICK) begin
            state_d = ST_TICK;
          end
        end
      end
      ST_ADD: begin
        cmd_o.add_step = 1'b1;
        if (sts_i.slot_free || sts_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_TICK_END;
        end
      end
      ST_TICK_END: begin
        cmd_o.tick_end = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/ptb_dpath.sv -----
// ----------------------------------------------------------------------------
// ptb_dpath: datapath of the periodic timer bank
// Live bits, slot RAM, elapsed time, slot walk and the result register.
// ----------------------------------------------------------------------------
module ptb_dpath
  import ptb_pkg::*;
#(
  parameter int unsigned TIMERS = TIMERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IDX_W   = $clog2(TIMERS);
  localparam int unsigned WORD_W  = PER_W + REM_W;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMERS - 1);

  req_t              req_q;
  logic [63:0]       prev_q, prev_d;
  logic [ELAP_W-1:0] elapsed_q, elapsed_d;
  logic [TIMERS-1:0] live_q, live_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]  pend_id_q, pend_id_d;
  logic              res_vld_q, res_vld_d;
  res_t              res_q, res_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [63:0]        diff;
  logic [IDX_W+3:0]   rm_ext;
  logic [IDX_W-1:0]   rm_idx;
  logic               rm_hit;
  logic [REM_W-1:0]   cur_rem;
  logic [PER_W-1:0]   cur_per;
  logic signed [35:0] r_sub, r_rel;
  logic               clamped, fire;
  logic [REM_W-1:0]   new_rem;

  function automatic logic [3:0] slot_of(logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

  ptb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TIMERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cur_rem = ram_rdata[REM_W-1:0];
  assign cur_per = ram_rdata[WORD_W-1:REM_W];

  // Remaining minus elapsed, and the same with the period already added.
  assign r_sub = {{2{cur_rem[REM_W-1]}}, cur_rem} - {3'b000, elapsed_q};
  assign r_rel = {{2{cur_rem[REM_W-1]}}, cur_rem} - {3'b000, elapsed_q}
               + {4'b0000, cur_per};
  assign clamped = r_sub < REM_MIN_36;
  assign fire    = r_sub[35] || (r_sub == '0);

  always_comb begin
    if (!fire) begin
      new_rem = r_sub[REM_W-1:0];
    end else if (clamped) begin
      // The floor has zero low bits, so adding the period is a concatenation.
      new_rem = {2'b10, cur_per};
    end else begin
      new_rem = r_rel[REM_W-1:0];
    end
  end

  assign diff   = req_i.now_time - prev_q;
  assign rm_ext = {{IDX_W{1'b0}}, req_i.timer_id};
  assign rm_idx = rm_ext[IDX_W-1:0];
  assign rm_hit = (int'(req_i.timer_id) < int'(TIMERS)) && live_q[rm_idx];

  assign sts_o.idx_last  = idx_q == IDX_LAST;
  assign sts_o.slot_free = !live_q[idx_q];

  always_comb begin
    ram_raddr = '0;
    if (cmd_i.tick_step && idx_q != IDX_LAST) begin
      ram_raddr = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {cur_per, new_rem};
    if (cmd_i.add_step) begin
      ram_we    = !live_q[idx_q];
      ram_wdata = {req_q.period, {(REM_W - PER_W){1'b0}}, req_q.period};
    end else if (cmd_i.tick_step) begin
      ram_we = live_q[idx_q];
    end
  end

  always_comb begin
    prev_d     = prev_q;
    elapsed_d  = elapsed_q;
    live_d     = live_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;

    if (cmd_i.accept) begin
      idx_d      = '0;
      cnt_d      = '0;
      pend_vld_d = 1'b0;
      if (req_i.mode == MODE_REMOVE) begin
        res_vld_d     = 1'b1;
        res_d.kind    = KIND_REMOVE;
        res_d.slot_id = req_i.timer_id;
        res_d.status  = rm_hit ? STATUS_OK : STATUS_NOT_FOUND;
        res_d.last    = 1'b1;
        if (rm_hit) begin
          live_d[rm_idx] = 1'b0;
        end
      end else if (req_i.mode == MODE_TICK) begin
        prev_d = req_i.now_time;
        if (prev_q == '1) begin
          elapsed_d = '0;
        end else if ((|diff[63:33]) || (diff[32] && (|diff[31:0]))) begin
          elapsed_d = ELAPSED_MAX;
        end else begin
          elapsed_d = diff[ELAP_W-1:0];
        end
      end
    end

    if (cmd_i.add_step) begin
      idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
      if (!live_q[idx_q]) begin
        live_d[idx_q] = 1'b1;
        res_vld_d     = 1'b1;
        res_d.kind    = KIND_ADD;
        res_d.slot_id = slot_of(idx_q);
        res_d.status  = STATUS_OK;
        res_d.last    = 1'b1;
      end else if (idx_q == IDX_LAST) begin
        res_vld_d     = 1'b1;
        res_d.kind    = KIND_ADD;
        res_d.slot_id = '0;
        res_d.status  = STATUS_FULL;
        res_d.last    = 1'b1;
      end
    end

    // A fired slot is held back one find, so the final one can carry last.
    if (cmd_i.tick_step) begin
      idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
      if (live_q[idx_q] && fire && (cnt_q < CNT_W'(MAX_RES))) begin
        if (pend_vld_q) begin
          res_vld_d     = 1'b1;
          res_d.kind    = KIND_FIRED;
          res_d.slot_id = slot_of(pend_id_q);
          res_d.status  = STATUS_OK;
          res_d.last    = 1'b0;
        end
        pend_vld_d = 1'b1;
        pend_id_d  = idx_q;
        cnt_d      = cnt_q + CNT_W'(1);
      end
    end

    if (cmd_i.tick_end) begin
      pend_vld_d = 1'b0;
      if (pend_vld_q) begin
        res_vld_d     = 1'b1;
        res_d.kind    = KIND_FIRED;
        res_d.slot_id = slot_of(pend_id_q);
        res_d.status  = STATUS_OK;
        res_d.last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '1;
      live_q     <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      prev_q     <= prev_d;
      live_q     <= live_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    elapsed_q <= elapsed_d;
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/periodic_timer_bank.sv -----
// Remove: busy does not rise; its answer strobes in the cycle after the transfer.
// Add: busy while the live bits are walked one slot per cycle; the answer strobes
// in the same cycle that busy falls.
// Tick: busy for the one-slot-per-cycle RAM walk over all slots and the end step;
// the last fired id strobes in the same cycle that busy falls. Results cannot be
// stalled. Reset (async, active low) frees all slots and marks that no tick has
// been seen; the slot RAM needs no clearing.
// ----------------------------------------------------------------------------
// periodic_timer_bank: bank of periodic timers
// Add, remove and tick requests on a start/busy command port; answers and
// fired timer ids come out as single-cycle strobed results.
// ----------------------------------------------------------------------------
module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int unsigned TIMERS = TIMERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  // The controller only sequences; every register that holds timer state
  // lives in the datapath. The two talk through the command and status
  // groups below.
  cmd_t cmd;
  sts_t sts;

  ptb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .mode_i (req_i.mode),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // The datapath takes the request in the transfer cycle: a remove is
  // finished there, a tick computes its elapsed time there, and the slot
  // walks that follow use the captured request.
  ptb_dpath #(
    .TIMERS(TIMERS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
